// ----- rtl/bpmc_pkg.sv -----
// Package: shared types and constants for the button press mode controller.
`timescale 1ns / 1ps

package bpmc_pkg;

  // Fixed field widths
  localparam int unsigned DEB_W   = 10;
  localparam int unsigned LONG_W  = 16;
  localparam int unsigned BLINK_W = 8;
  localparam int unsigned HELD_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]   DEB_RESET   = 10'd50;
  localparam logic [LONG_W-1:0]  LONG_RESET  = 16'd500;
  localparam logic [BLINK_W-1:0] BLINK_RESET = 8'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD   = 2'd2;

  // Operating mode
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PLAY     = 2'd1,
    MODE_REC      = 2'd2,
    MODE_REC_STOP = 2'd3
  } mode_t;

  // Input beat: one millisecond tick
  typedef struct packed {
    logic button_level;
    logic record_started;
    logic record_stopped;
    logic playback_done;
  } in_t;

  // Result beat
  typedef struct packed {
    mode_t mode;
    logic  stop_recording;
    logic  indicator_lamp;
    logic  done_lamp;
  } out_t;

  // Debounce events for the current tick
  typedef struct packed {
    logic press;    // debounced press recognized
    logic release_; // debounced release recognized
    logic pressed;  // debounced level after this tick
  } btn_evt_t;

endpackage

// ----- rtl/bpmc_debounce.sv -----
// Debouncer: saturating press and release counters and the debounced level.
`timescale 1ns / 1ps

module bpmc_debounce
  import bpmc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             button_level,
  input  logic [DEB_W-1:0] debounce_ticks,
  output btn_evt_t         evt
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > DEB_W) ? COUNT_WIDTH : DEB_W;

  logic [COUNT_WIDTH-1:0] press_count;
  logic [COUNT_WIDTH-1:0] release_count;
  logic                   pressed_flag;
  logic [COUNT_WIDTH-1:0] press_count_next;
  logic [COUNT_WIDTH-1:0] release_count_next;
  logic                   press_hit;
  logic                   release_hit;

  // Count the raw level, saturating, clear the opposite counter
  always_comb begin
    if (button_level) begin
      press_count_next   = (&press_count) ? press_count : press_count + 1'b1;
      release_count_next = '0;
    end else begin
      press_count_next   = '0;
      release_count_next = (&release_count) ? release_count : release_count + 1'b1;
    end
    press_hit   = CMP_W'(press_count_next) > CMP_W'(debounce_ticks);
    release_hit = CMP_W'(release_count_next) > CMP_W'(debounce_ticks);
    evt.press    = press_hit && !pressed_flag;
    evt.release_ = !evt.press && release_hit && pressed_flag;
    evt.pressed  = evt.press ? 1'b1 : (evt.release_ ? 1'b0 : pressed_flag);
  end

  // Advance counters once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      press_count   <= '0;
      release_count <= '0;
      pressed_flag  <= 1'b0;
    end else if (fire) begin
      press_count   <= press_count_next;
      release_count <= release_count_next;
      pressed_flag  <= evt.pressed;
    end
  end

  // At most one counter runs at a time
  a_one_counter: assert property (@(posedge clk) disable iff (rst)
    !((press_count != '0) && (release_count != '0)))
    else $error("press and release counters both running");

  // A press is only recognized from the released level
  a_press_edge: assert property (@(posedge clk) disable iff (rst)
    fire && evt.press |=> pressed_flag && !$past(pressed_flag))
    else $error("press recognized while already pressed");

endmodule

// ----- rtl/bpmc_mode.sv -----
// Mode controller: events, held time, mode transitions, blink and lamps.
`timescale 1ns / 1ps

module bpmc_mode
  import bpmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  in_t                tick,
  input  btn_evt_t           evt,
  input  logic [LONG_W-1:0]  long_press_ms,
  input  logic [BLINK_W-1:0] blink_period,
  output out_t               res
);

  logic [HELD_W-1:0]  held_ms;
  mode_t              mode_reg;
  logic               blinking;
  logic [BLINK_W-1:0] blink_count;
  logic               indicator_reg;
  logic               done_reg;

  logic [HELD_W-1:0]  held_ms_next;
  mode_t              mode_reg_next;
  logic               blinking_next;
  logic [BLINK_W-1:0] blink_count_next;
  logic               indicator_reg_next;
  logic               done_reg_next;
  logic               stop_pulse;

  // Apply events, then button logic, then blink and lamps
  always_comb begin
    mode_reg_next      = mode_reg;
    blinking_next      = blinking | tick.record_started;
    blink_count_next   = blink_count;
    indicator_reg_next = indicator_reg;
    done_reg_next      = done_reg;
    stop_pulse         = 1'b0;

    if (tick.record_stopped && (mode_reg == MODE_REC)) begin
      mode_reg_next = MODE_REC_STOP;
    end
    if (tick.playback_done) begin
      mode_reg_next = MODE_IDLE;
    end

    // saturate held time, restart on a press
    held_ms_next = (&held_ms) ? held_ms : held_ms + 1'b1;
    if (evt.press) begin
      held_ms_next = '0;
    end else if (evt.release_) begin
      if ((mode_reg_next == MODE_IDLE) && (held_ms_next < long_press_ms)) begin
        mode_reg_next = MODE_PLAY;
      end else if ((mode_reg_next == MODE_PLAY) || (mode_reg_next == MODE_REC_STOP)) begin
        mode_reg_next = MODE_IDLE;
      end else if (mode_reg_next == MODE_REC) begin
        stop_pulse    = 1'b1;
        mode_reg_next = MODE_IDLE;
        done_reg_next = 1'b1;
      end
    end

    // long hold in idle starts recording
    if ((mode_reg_next == MODE_IDLE) && evt.pressed && (held_ms_next > long_press_ms)) begin
      mode_reg_next = MODE_REC;
    end

    // blink timer
    if (blinking_next) begin
      blink_count_next = blink_count + 1'b1;
      if (blink_count_next > blink_period) begin
        blink_count_next   = '0;
        indicator_reg_next = ~indicator_reg;
      end
    end

    // mode lamps override the blink
    if (mode_reg_next == MODE_IDLE) begin
      indicator_reg_next = 1'b0;
      blinking_next      = 1'b0;
    end else if (mode_reg_next == MODE_PLAY) begin
      indicator_reg_next = 1'b1;
      blinking_next      = 1'b0;
    end

    res.mode           = mode_reg_next;
    res.stop_recording = stop_pulse;
    res.indicator_lamp = indicator_reg_next;
    res.done_lamp      = done_reg_next;
  end

  // Commit state once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      held_ms       <= '0;
      mode_reg      <= MODE_IDLE;
      blinking      <= 1'b0;
      blink_count   <= '0;
      indicator_reg <= 1'b0;
      done_reg      <= 1'b0;
    end else if (fire) begin
      held_ms       <= held_ms_next;
      mode_reg      <= mode_reg_next;
      blinking      <= blinking_next;
      blink_count   <= blink_count_next;
      indicator_reg <= indicator_reg_next;
      done_reg      <= done_reg_next;
    end
  end

  // Stopping a recording lands in idle with the done lamp lit
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.stop_recording |-> (res.mode == MODE_IDLE) && res.done_lamp)
    else $error("stop pulse without idle and done lamp");

  // Done lamp is sticky
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_reg |=> done_reg)
    else $error("done lamp dropped");

  // Idle keeps the indicator dark and blinking off; playing keeps it lit
  a_lamp_mode: assert property (@(posedge clk)
    ((mode_reg == MODE_IDLE) |-> (!indicator_reg && !blinking)) and
    ((mode_reg == MODE_PLAY) |-> (indicator_reg && !blinking)))
    else $error("indicator does not follow mode");

endmodule

// ----- rtl/button_press_mode_controller_core.sv -----
// Top level: input register, debouncer, mode controller and result register.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall   in_data  (in_t)
//   out       source     out_valid / out_stall out_data (out_t)
//   cfg       sink       cfg_we                cfg_index, cfg_data
//
// One tick beat is accepted every cycle while in_stall is low; its result is written
// into the result register when the beat leaves the input register, and is held there until taken.
// All state updates for a tick happen in the cycle it moves from the
// input register into the result register.
// Reset clears control state and loads the register defaults (50, 500, 100).
// A stall on out backs up through the result register into in_stall in the
// same cycle once both registers are full.
`timescale 1ns / 1ps

module button_press_mode_controller_core
  import bpmc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [DEB_W-1:0]   debounce_ticks;
  logic [LONG_W-1:0]  long_press_ms;
  logic [BLINK_W-1:0] blink_period;

  logic     s1_valid;
  in_t      s1_data;
  logic     out_free;
  logic     fire;
  btn_evt_t evt;
  out_t     res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEB_RESET;
      long_press_ms  <= LONG_RESET;
      blink_period   <= BLINK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data[DEB_W-1:0];
        CFG_LONG_PRESS_MS:  long_press_ms  <= cfg_data[LONG_W-1:0];
        CFG_BLINK_PERIOD:   blink_period   <= cfg_data[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  bpmc_debounce #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .button_level   (s1_data.button_level),
    .debounce_ticks (debounce_ticks),
    .evt            (evt)
  );

  bpmc_mode u_mode (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .tick          (s1_data),
    .evt           (evt),
    .long_press_ms (long_press_ms),
    .blink_period  (blink_period),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  // Input side only stalls when the input register holds a beat
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

endmodule

// ----- tb/sv/tb_button_press_mode_controller_core.sv -----
// Testbench for the button press mode controller: random gestures checked against a predictor.
`timescale 1ns / 1ps

module tb_button_press_mode_controller_core;
  import bpmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Predicts the result beat of every tick and checks what the block returns
  class mode_scoreboard;
    logic [DEB_W-1:0]   debounce_ticks;
    logic [LONG_W-1:0]  long_press_ms;
    logic [BLINK_W-1:0] blink_period;
    logic [15:0]        press_cnt;
    logic [15:0]        rel_cnt;
    logic               pressed;
    logic [HELD_W-1:0]  held_ms;
    mode_t              mode;
    logic               blinking;
    logic [7:0]         blink_cnt;
    logic               lamp;
    logic               done;
    out_t               expected_q[$];
    int unsigned        mismatches;

    function new();
      debounce_ticks = DEB_RESET;
      long_press_ms  = LONG_RESET;
      blink_period   = BLINK_RESET;
      press_cnt  = '0;
      rel_cnt    = '0;
      pressed    = 1'b0;
      held_ms    = '0;
      mode       = MODE_IDLE;
      blinking   = 1'b0;
      blink_cnt  = '0;
      lamp       = 1'b0;
      done       = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_DEBOUNCE_TICKS: debounce_ticks = val[DEB_W-1:0];
        CFG_LONG_PRESS_MS:  long_press_ms  = val[LONG_W-1:0];
        CFG_BLINK_PERIOD:   blink_period   = val[BLINK_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the state by one accepted tick and queue the result it causes
    function void note_tick(in_t t);
      out_t r;
      logic stop_pulse;
      stop_pulse = 1'b0;

      // recorder and playback events come first
      if (t.record_started) blinking = 1'b1;
      if (t.record_stopped && mode == MODE_REC) mode = MODE_REC_STOP;
      if (t.playback_done) mode = MODE_IDLE;

      // held time and saturating debounce counters
      if (held_ms != '1) held_ms++;
      if (t.button_level) begin
        if (press_cnt != '1) press_cnt++;
        rel_cnt = '0;
      end else begin
        if (rel_cnt != '1) rel_cnt++;
        press_cnt = '0;
      end

      if (press_cnt > debounce_ticks && !pressed) begin
        pressed = 1'b1;
        held_ms = '0;
      end else if (rel_cnt > debounce_ticks && pressed) begin
        pressed = 1'b0;
        if (mode == MODE_IDLE && held_ms < long_press_ms) begin
          mode = MODE_PLAY;
        end else if (mode == MODE_PLAY || mode == MODE_REC_STOP) begin
          mode = MODE_IDLE;
        end else if (mode == MODE_REC) begin
          stop_pulse = 1'b1;
          mode = MODE_IDLE;
          done = 1'b1;
        end
      end

      // long hold in idle starts recording
      if (mode == MODE_IDLE && pressed && held_ms > long_press_ms) mode = MODE_REC;

      // blink counter wraps at 8 bits
      if (blinking) begin
        blink_cnt++;
        if (blink_cnt > blink_period) begin
          blink_cnt = '0;
          lamp = ~lamp;
        end
      end

      // idle and playing force the lamp and cancel blinking
      if (mode == MODE_IDLE) begin
        lamp = 1'b0;
        blinking = 1'b0;
      end else if (mode == MODE_PLAY) begin
        lamp = 1'b1;
        blinking = 1'b0;
      end

      r.mode = mode;
      r.stop_recording = stop_pulse;
      r.indicator_lamp = lamp;
      r.done_lamp = done;
      expected_q.push_back(r);
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, want, got);
    endfunction

    // Compare one result beat against the oldest prediction
    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        flag("unexpected result beat, mode", -1, got.mode);
        return;
      end
      want = expected_q.pop_front();
      if (got.mode !== want.mode) flag("mode", want.mode, got.mode);
      if (got.stop_recording !== want.stop_recording)
        flag("stop_recording", want.stop_recording, got.stop_recording);
      if (got.indicator_lamp !== want.indicator_lamp)
        flag("indicator_lamp", want.indicator_lamp, got.indicator_lamp);
      if (got.done_lamp !== want.done_lamp) flag("done_lamp", want.done_lamp, got.done_lamp);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE_TICKS;
  logic [CFG_W-1:0]     cfg_data = '0;

  mode_scoreboard sb;
  logic           idling = 1'b1;
  int unsigned    ticks_sent = 0;
  int unsigned    cycles = 0;

  button_press_mode_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Stall the result side in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_t make_tick(logic level, logic started, logic stopped, logic finished);
    in_t t;
    t.button_level   = level;
    t.record_started = started;
    t.record_stopped = stopped;
    t.playback_done  = finished;
    return t;
  endfunction

  // Offer one tick beat, with an optional gap before it, and hold it until taken
  task automatic send_tick(input in_t t);
    if (idling && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
    ticks_sent++;
  endtask

  task automatic repeat_tick(input in_t t, input int unsigned n);
    repeat (n) send_tick(t);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic write_config(input int unsigned deb, input int unsigned hold_ms,
                              input int unsigned period);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_TICKS;
    cfg_data  <= CFG_W'(deb);
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS_MS;
    cfg_data  <= CFG_W'(hold_ms);
    @(posedge clk);
    cfg_index <= CFG_BLINK_PERIOD;
    cfg_data  <= CFG_W'(period);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_DEBOUNCE_TICKS, CFG_W'(deb));
    sb.set_register(CFG_LONG_PRESS_MS, CFG_W'(hold_ms));
    sb.set_register(CFG_BLINK_PERIOD, CFG_W'(period));
  endtask

  // One press and release, with contact bounce near both edges and random events
  task automatic run_gesture(input int unsigned hold, input int unsigned rest);
    in_t t;
    for (int unsigned i = 0; i < hold + rest; i++) begin
      t.button_level = (i < hold);
      if ((i < 3 || (i >= hold && i < hold + 3)) && $urandom_range(0, 3) == 0)
        t.button_level = ~t.button_level;
      t.record_started = ($urandom_range(0, 7) == 0);
      t.record_stopped = ($urandom_range(0, 29) == 0);
      t.playback_done  = ($urandom_range(0, 49) == 0);
      send_tick(t);
    end
  endtask

  // Mostly well-formed short and long presses, some pure noise
  task automatic random_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned deb;
    int unsigned lp;
    int unsigned kind;
    stop_at = ticks_sent + budget;
    deb = sb.debounce_ticks;
    lp  = sb.long_press_ms;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        repeat ($urandom_range(5, 30)) send_tick(in_t'(($bits(in_t))'($urandom)));
      end else if (kind < 6) begin
        run_gesture(deb + 1 + $urandom_range(0, lp), deb + 1 + $urandom_range(0, 20));
      end else begin
        run_gesture(deb + lp + $urandom_range(1, 40), deb + 1 + $urandom_range(0, 20));
      end
    end
  endtask

  initial begin
    int unsigned deb;
    int unsigned lp;
    int unsigned period;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: all-zero, all-one and each event alone
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
    drain_results();

    // Long press to record, blink, release to stop; then short press to play
    write_config(1, 3, 1);
    repeat_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0), 6);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0));
    repeat_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0), 3);
    repeat_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0), 2);
    repeat_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0), 2);
    repeat_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0), 2);
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
    drain_results();

    // Largest settings with the button held, then a release in idle after exactly
    // the long-press time, which leaves the mode alone
    idling = 1'b0;
    write_config(1023, 65535, 255);
    repeat_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0), 20);
    repeat_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0), 2);
    drain_results();
    write_config(1, 10, 255);
    repeat_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0), 10);
    repeat_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0), 5);
    drain_results();

    // Random phases over several settings; the last one runs without idling
    for (int p = 0; p < 6; p++) begin
      idling = (p != 5);
      case (p)
        0: begin deb = 1; lp = 1; period = 1; end
        1: begin deb = 2; lp = 15; period = 255; end
        default: begin
          deb = $urandom_range(1, 6);
          lp  = $urandom_range(1, 60);
          period = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 12);
        end
      endcase
      write_config(deb, lp, period);
      random_phase(120);
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bpmc_pkg.sv
rtl/bpmc_debounce.sv
rtl/bpmc_mode.sv
rtl/button_press_mode_controller_core.sv
tb/sv/tb_button_press_mode_controller_core.sv
